>>> src/consensus_log_replication_tracker_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef CONSENSUS_LOG_REPLICATION_TRACKER_UNIT_DEFINES_SVH
`define CONSENSUS_LOG_REPLICATION_TRACKER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CLRT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CLRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/clrt_pkg.sv
// ----------------------------------------------------------------------------
// clrt_pkg
// Shared types and constants of the log replication tracker.
// ----------------------------------------------------------------------------
package clrt_pkg;

    localparam int P_PEERS_DEF     = 4;
    localparam int P_LOG_DEPTH_DEF = 1024;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 176;

    localparam logic [2:0] KIND_APPEND = 3'd0;
    localparam logic [2:0] KIND_INIT   = 3'd1;
    localparam logic [2:0] KIND_RESP   = 3'd2;
    localparam logic [2:0] KIND_BUILD  = 3'd3;
    localparam logic [2:0] KIND_CUT    = 3'd4;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    localparam logic CFG_IDX_PEER_COUNT = 1'b0;
    localparam logic CFG_IDX_MAX_BATCH  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MED,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic med;
        logic check;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic need_med;
        logic need_read;
        logic out_free;
    } t_dp_stat;

endpackage

>>> src/clrt_ram.sv
// ----------------------------------------------------------------------------
// clrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/clrt_datapath.sv
// ----------------------------------------------------------------------------
// clrt_datapath
// Log state, peer tables, term ring, median select and result register.
// ----------------------------------------------------------------------------
module clrt_datapath #(
    parameter int PEERS     = 4,
    parameter int LOG_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  clrt_pkg::t_dp_cmd             i_cmd,
    output clrt_pkg::t_dp_stat            o_stat,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [10:0]                   i_cfg_data,
    input  logic [clrt_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic [2:0]                    i_in_kind,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [clrt_pkg::OUT_DATA_W-1:0] o_out_data,
    output logic [1:0]                    o_out_status
);
    import clrt_pkg::*;

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int NV = PEERS + 1;
    localparam int RW = $clog2(NV + 1);

    // configuration
    logic [2:0]  r_peer_count;
    logic [10:0] r_max_batch;

    // log state
    logic [31:0]   r_last, r_commit, r_base, r_base_term;
    logic [AW-1:0] r_last_ptr;
    logic [31:0]   r_next  [PEERS];
    logic [31:0]   r_match [PEERS];
    logic [PEERS-1:0] r_valid;

    // captured transaction
    logic [2:0]  r_kind;
    logic [1:0]  r_peer;
    logic [31:0] r_term, r_index, r_conflict, r_resp_term;
    logic        r_ok;

    // working result
    logic [1:0]  r_status;
    logic [31:0] r_idx, r_pterm, r_first, r_qidx;
    logic [10:0] r_count;
    logic        r_snap;

    // result register
    logic        r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [1:0]  r_out_status;

    // peer select
    logic        sel_valid;
    logic [31:0] sel_next, sel_match;
    logic        peer_ok;
    logic        resp_ok;

    always_comb begin
        sel_valid = 1'b0;
        sel_next  = '0;
        sel_match = '0;
        for (int i = 0; i < PEERS; i++) begin
            if ({30'd0, r_peer} == 32'(i)) begin
                sel_valid = r_valid[i];
                sel_next  = r_next[i];
                sel_match = r_match[i];
            end
        end
    end

    assign peer_ok = {30'd0, r_peer} < 32'(PEERS);
    assign resp_ok = (r_resp_term <= r_term) && peer_ok && sel_valid;

    // append
    logic          app_full, app_sat, app_ok;
    logic [AW-1:0] app_ptr;

    assign app_full = (r_last - r_base) >= 32'(LOG_DEPTH);
    assign app_sat  = r_last >= 32'hFFFF_FFFE;
    assign app_ok   = !app_full && !app_sat;
    assign app_ptr  = (r_last_ptr == AW'(LOG_DEPTH - 1)) ? '0 : r_last_ptr + AW'(1);

    // build
    logic [31:0] b_nx0, b_nx, b_avail;
    logic [10:0] b_batch, b_count;
    logic        b_snap;

    always_comb begin
        b_nx0   = sel_valid ? sel_next : r_last + 32'd1;
        b_snap  = sel_valid && (sel_next <= r_base);
        b_nx    = (b_nx0 <= r_base) ? r_base + 32'd1 : b_nx0;
        b_avail = r_last - b_nx + 32'd1;
        b_batch = (r_max_batch > 11'd1024) ? 11'd1024 : r_max_batch;
        if (b_nx <= r_last) begin
            b_count = (b_avail < {21'd0, b_batch}) ? b_avail[10:0] : b_batch;
        end else begin
            b_count = '0;
        end
    end

    // median of leader last index and valid match values, by rank
    logic [31:0]   mv    [NV];
    logic          minc  [NV];
    logic [RW-1:0] mrank [NV];
    logic [RW-1:0] mcnt;
    logic [31:0]   med_q;

    always_comb begin
        mv[0]   = r_last;
        minc[0] = 1'b1;
        mcnt    = RW'(1);
        for (int i = 0; i < PEERS; i++) begin
            mv[i+1]   = r_match[i];
            minc[i+1] = r_valid[i];
            mcnt      = mcnt + RW'(r_valid[i]);
        end
        med_q = '0;
        for (int j = 0; j < NV; j++) begin
            mrank[j] = '0;
            for (int i = 0; i < NV; i++) begin
                if (minc[i] && ((mv[i] < mv[j]) || ((mv[i] == mv[j]) && (i < j)))) begin
                    mrank[j] = mrank[j] + RW'(1);
                end
            end
            if (minc[j] && (mrank[j] == (mcnt >> 1))) begin
                med_q = mv[j];
            end
        end
    end

    // ring address of r_qidx relative to the last entry's slot
    logic [31:0]   rd_diff;
    logic [AW:0]   rd_tmp;
    logic [AW-1:0] rd_addr;
    logic [31:0]   ram_rdata;
    logic [31:0]   t_val;

    always_comb begin
        rd_diff = r_last - r_qidx;
        rd_tmp  = {1'b0, r_last_ptr} - {1'b0, rd_diff[AW-1:0]};
        if (rd_tmp[AW]) begin
            rd_tmp = rd_tmp + (AW+1)'(LOG_DEPTH);
        end
        rd_addr = rd_tmp[AW-1:0];
    end

    always_comb begin
        if (r_qidx == r_base) begin
            t_val = r_base_term;
        end else if ((r_qidx == 32'd0) || (r_qidx > r_last) || (r_qidx <= r_base)) begin
            t_val = '0;
        end else begin
            t_val = ram_rdata;
        end
    end

    clrt_ram #(
        .WIDTH (32),
        .DEPTH (LOG_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && (r_kind == KIND_APPEND) && app_ok),
        .i_waddr (app_ptr),
        .i_wdata (r_term),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer_count <= 3'd4;
            r_max_batch  <= 11'd64;
            r_last       <= '0;
            r_commit     <= '0;
            r_base       <= '0;
            r_base_term  <= '0;
            r_last_ptr   <= '0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < PEERS; i++) begin
                r_next[i]  <= '0;
                r_match[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_PEER_COUNT) begin
                    r_peer_count <= i_cfg_data[2:0];
                end else begin
                    r_max_batch <= i_cfg_data;
                end
            end
            if (i_cmd.exec) begin
                case (r_kind)
                    KIND_APPEND: begin
                        if (app_ok) begin
                            r_last     <= r_last + 32'd1;
                            r_last_ptr <= app_ptr;
                        end
                    end
                    KIND_INIT: begin
                        for (int i = 0; i < PEERS; i++) begin
                            r_valid[i] <= 32'(i) < {29'd0, r_peer_count};
                            r_next[i]  <= (32'(i) < {29'd0, r_peer_count}) ?
                                          r_last + 32'd1 : 32'd0;
                            r_match[i] <= (32'(i) < {29'd0, r_peer_count}) ? r_base : 32'd0;
                        end
                    end
                    KIND_RESP: begin
                        for (int i = 0; i < PEERS; i++) begin
                            if (resp_ok && ({30'd0, r_peer} == 32'(i))) begin
                                if (r_ok) begin
                                    if (r_index > r_match[i]) begin
                                        r_match[i] <= r_index;
                                    end
                                    if (r_index == 32'hFFFF_FFFF) begin
                                        r_next[i] <= 32'hFFFF_FFFF;
                                    end else if (r_index + 32'd1 > r_next[i]) begin
                                        r_next[i] <= r_index + 32'd1;
                                    end
                                end else if (r_conflict != 32'd0) begin
                                    r_next[i] <= r_conflict;
                                end else if (r_next[i] > r_base + 32'd1) begin
                                    r_next[i] <= r_next[i] - 32'd1;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.check) begin
                if (r_kind == KIND_RESP) begin
                    if ((r_qidx > r_commit) && (r_qidx <= r_last) && (t_val == r_term)) begin
                        r_commit <= r_qidx;
                    end
                end else if (r_kind == KIND_CUT) begin
                    if ((r_qidx > r_base) && (r_qidx <= r_commit) && (t_val != 32'd0)) begin
                        r_base      <= r_qidx;
                        r_base_term <= t_val;
                    end
                end
            end
            if (i_cmd.fin && o_stat.out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction payload and working result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind      <= i_in_kind;
            r_peer      <= i_in_data[1:0];
            r_term      <= i_in_data[33:2];
            r_index     <= i_in_data[65:34];
            r_conflict  <= i_in_data[97:66];
            r_resp_term <= i_in_data[129:98];
            r_ok        <= i_in_data[130];
            r_status    <= STAT_IGNORED;
            r_idx       <= '0;
            r_pterm     <= '0;
            r_first     <= '0;
            r_count     <= '0;
            r_snap      <= 1'b0;
        end
        if (i_cmd.exec) begin
            case (r_kind)
                KIND_APPEND: begin
                    if (app_full) begin
                        r_status <= STAT_FULL;
                    end else if (app_ok) begin
                        r_status <= STAT_DONE;
                        r_idx    <= r_last + 32'd1;
                    end
                end
                KIND_INIT: begin
                    r_status <= STAT_DONE;
                end
                KIND_RESP: begin
                    if (resp_ok) begin
                        r_status <= STAT_DONE;
                    end
                end
                KIND_BUILD: begin
                    if (peer_ok) begin
                        r_status <= STAT_DONE;
                        r_idx    <= b_nx - 32'd1;
                        r_qidx   <= b_nx - 32'd1;
                        r_first  <= b_nx;
                        r_count  <= b_count;
                        r_snap   <= b_snap;
                    end
                end
                KIND_CUT: begin
                    r_qidx <= r_index;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.med) begin
            r_qidx <= med_q;
        end
        if (i_cmd.check) begin
            if (r_kind == KIND_BUILD) begin
                r_pterm <= t_val;
            end else if ((r_kind == KIND_CUT) && (r_qidx > r_base) &&
                         (r_qidx <= r_commit) && (t_val != 32'd0)) begin
                r_status <= STAT_DONE;
            end
        end
        if (i_cmd.fin && o_stat.out_free) begin
            r_out_status <= r_status;
            r_out_data   <= {4'd0, r_last, r_snap, r_commit, r_count,
                             r_first, r_pterm, r_idx};
        end
    end

    always_comb begin
        o_stat.need_med  = (r_kind == KIND_RESP) && resp_ok && r_ok;
        o_stat.need_read = ((r_kind == KIND_BUILD) && peer_ok) || (r_kind == KIND_CUT);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_out_status = r_out_status;

endmodule

>>> src/clrt_ctrl.sv
// ----------------------------------------------------------------------------
// clrt_ctrl
// Event sequencer: capture, execute, median, ring read, check, deliver.
// ----------------------------------------------------------------------------
module clrt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  clrt_pkg::t_dp_stat i_stat,
    output clrt_pkg::t_dp_cmd  o_cmd
);
    import clrt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.need_med) n_state = S_MED;
                else if (i_stat.need_read) n_state = S_READ;
                else n_state = S_DONE;
            end
            S_MED:   n_state = S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC:  o_cmd.exec  = 1'b1;
            S_MED:   o_cmd.med   = 1'b1;
            S_READ:  o_cmd       = '0;
            S_CHECK: o_cmd.check = 1'b1;
            S_DONE:  o_cmd.fin   = 1'b1;
            default: o_cmd       = '0;
        endcase
    end

endmodule

>>> src/consensus_log_replication_tracker_unit.sv
// ----------------------------------------------------------------------------
// consensus_log_replication_tracker_unit
// Leader-side log replication tracker: term ring, commit and peer indexes.
// ----------------------------------------------------------------------------
// Append, init, ignored events and failed responses pass from execute to the result
// register; build and snapshot cut add a term ring read and check, and a successful
// response adds median select before the ring read. One event is handled at a time:
// a new event is accepted once the last result is registered, which an output stall delays.
// Reset (synchronous, active low) clears indexes and peer tables, restores
// peer_count 4 and max_batch 64; the term ring is not cleared.
module consensus_log_replication_tracker_unit #(
    parameter int PEERS     = clrt_pkg::P_PEERS_DEF,
    parameter int LOG_DEPTH = clrt_pkg::P_LOG_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [10:0]                     i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // peer[1:0], term_in[33:2], index_in[65:34], conflict_in[97:66],
    // resp_term[129:98], resp_success[130], zero fill
    input  logic [clrt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // index_out[31:0], prev_term_out[63:32], first_send[95:64],
    // send_count[106:96], commit_out[138:107], needs_snapshot[139],
    // last_out[171:140], zero fill
    output logic [clrt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]                      m_axis_tuser
);
    import clrt_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    clrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    clrt_datapath #(
        .PEERS     (PEERS),
        .LOG_DEPTH (LOG_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_data    (s_axis_tdata),
        .i_in_kind    (s_axis_tuser),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser)
    );

endmodule

>>> src/clrt_checker.sv
// ----------------------------------------------------------------------------
// clrt_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "consensus_log_replication_tracker_unit_defines.svh"

module clrt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [175:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // a stalled result stays offered
    `CLRT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

    // one event in flight: no accept right after an accept
    `CLRT_ASSERT_NEXT(a_one_inflight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted back to back")

    `CLRT_ASSERT_NOW(a_status_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser != 2'd3, "undefined status code")

    `CLRT_ASSERT_NOW(a_commit_le_last, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[138:107] <= m_axis_tdata[171:140], "commit beyond last index")

    `CLRT_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[106:96] <= 11'd1024, "send count above cap")

endmodule

bind consensus_log_replication_tracker_unit clrt_checker u_clrt_checker (.*);

>>> verif/tb_consensus_log_replication_tracker_unit.sv
// ----------------------------------------------------------------------------
// tb_consensus_log_replication_tracker_unit
// Drives appends, leader inits, peer responses, request builds, snapshot cuts and
// undefined kinds into the tracker, with random gaps on both stream sides. Each result
// is compared field by field with a behavioral copy of the leader state or a typed reply.
// ----------------------------------------------------------------------------
module tb_consensus_log_replication_tracker_unit;
    import clrt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPEER = 4;
    localparam int DEPTH = 1024;

    typedef struct {
        logic [2:0]  kind;
        logic [1:0]  peer;
        logic [31:0] term;
        logic [31:0] idx;
        logic [31:0] conflict;
        logic [31:0] rterm;
        logic        ok;
    } t_event;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] idx_out;
        logic [31:0] prev_term;
        logic [31:0] first;
        logic [10:0] count;
        logic [31:0] commit;
        logic        snap;
        logic [31:0] last;
    } t_reply;

    typedef struct {
        t_event ev;
        bit     typed;
        t_reply rep;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_idx = 1'b0;
    logic [10:0]           i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [2:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    consensus_log_replication_tracker_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // leader state copy
    logic [31:0] ring_terms [0:DEPTH-1];
    logic [31:0] last_idx, commit_idx, base_idx, base_trm;
    logic [31:0] nxt [0:NPEER-1];
    logic [31:0] mtch [0:NPEER-1];
    logic        pvalid [0:NPEER-1];
    logic [2:0]  cfg_peers = 3'd4;
    logic [10:0] cfg_batch = 11'd64;

    t_reply      pending_replies [$];
    int          mismatches = 0;
    bit          calm = 1'b0;
    logic [31:0] cur_term = 32'd1;
    t_row        rows [$];
    int          sink_hold = 0;

    function automatic logic [31:0] term_of(logic [31:0] i);
        if (i == base_idx) return base_trm;
        if (i == 0 || i > last_idx || i <= base_idx) return 32'd0;
        return ring_terms[i[9:0]];
    endfunction

    task automatic try_commit(input logic [31:0] t);
        logic [31:0] v [0:NPEER];
        logic [31:0] x, q;
        int n, j;
        n = 1;
        v[0] = last_idx;
        for (int i = 0; i < NPEER; i++)
            if (pvalid[i]) begin
                v[n] = mtch[i];
                n++;
            end
        for (int i = 1; i < n; i++) begin
            x = v[i];
            j = i;
            while (j > 0 && v[j-1] > x) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = x;
        end
        q = v[n/2];
        if (q > commit_idx && q <= last_idx && term_of(q) == t) commit_idx = q;
    endtask

    task automatic predict(input t_event e, output t_reply r);
        logic [31:0] nx, avail, batch;
        int act;
        r = '{STAT_IGNORED, 0, 0, 0, 0, 0, 0, 0};
        case (e.kind)
            KIND_APPEND: begin
                if (last_idx - base_idx >= DEPTH) r.status = STAT_FULL;
                else if (last_idx < 32'hFFFF_FFFE) begin
                    last_idx++;
                    ring_terms[last_idx[9:0]] = e.term;
                    r.idx_out = last_idx;
                    r.status = STAT_DONE;
                end
            end
            KIND_INIT: begin
                act = cfg_peers < NPEER ? cfg_peers : NPEER;
                for (int i = 0; i < NPEER; i++) begin
                    pvalid[i] = i < act;
                    nxt[i] = i < act ? last_idx + 1 : 0;
                    mtch[i] = i < act ? base_idx : 0;
                end
                r.status = STAT_DONE;
            end
            KIND_RESP: begin
                if (e.rterm <= e.term && pvalid[e.peer]) begin
                    if (e.ok) begin
                        nx = e.idx == 32'hFFFF_FFFF ? e.idx : e.idx + 1;
                        if (e.idx > mtch[e.peer]) mtch[e.peer] = e.idx;
                        if (nx > nxt[e.peer]) nxt[e.peer] = nx;
                        try_commit(e.term);
                    end else if (e.conflict > 0) begin
                        nxt[e.peer] = e.conflict;
                    end else if (nxt[e.peer] > base_idx + 1) begin
                        nxt[e.peer]--;
                    end
                    r.status = STAT_DONE;
                end
            end
            KIND_BUILD: begin
                nx = last_idx + 1;
                batch = cfg_batch > DEPTH ? DEPTH : cfg_batch;
                if (pvalid[e.peer]) begin
                    nx = nxt[e.peer];
                    r.snap = nx <= base_idx;
                end
                if (nx <= base_idx) nx = base_idx + 1;
                r.idx_out = nx - 1;
                r.prev_term = term_of(nx - 1);
                r.first = nx;
                if (nx <= last_idx) begin
                    avail = last_idx - nx + 1;
                    r.count = 11'(avail < batch ? avail : batch);
                end
                r.status = STAT_DONE;
            end
            KIND_CUT: begin
                if (e.idx > base_idx && e.idx <= commit_idx && term_of(e.idx) != 0) begin
                    base_trm = term_of(e.idx);
                    base_idx = e.idx;
                    r.status = STAT_DONE;
                end
            end
            default: ;
        endcase
        r.commit = commit_idx;
        r.last = last_idx;
    endtask

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report(input string fld, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: %s got %h, want %h", $realtime, fld, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_reply w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                report("unexpected transaction", m_axis_tdata[31:0], 0);
            end else begin
                w = pending_replies.pop_front();
                if (m_axis_tuser !== w.status) report("status", m_axis_tuser, w.status);
                if (m_axis_tdata[31:0] !== w.idx_out)
                    report("index_out", m_axis_tdata[31:0], w.idx_out);
                if (m_axis_tdata[63:32] !== w.prev_term)
                    report("prev_term_out", m_axis_tdata[63:32], w.prev_term);
                if (m_axis_tdata[95:64] !== w.first)
                    report("first_send", m_axis_tdata[95:64], w.first);
                if (m_axis_tdata[106:96] !== w.count)
                    report("send_count", m_axis_tdata[106:96], w.count);
                if (m_axis_tdata[138:107] !== w.commit)
                    report("commit_out", m_axis_tdata[138:107], w.commit);
                if (m_axis_tdata[139] !== w.snap)
                    report("needs_snapshot", m_axis_tdata[139], w.snap);
                if (m_axis_tdata[171:140] !== w.last)
                    report("last_out", m_axis_tdata[171:140], w.last);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready = 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
            sink_hold = pick_gap();
        end
    end

    task automatic send(input t_event e, input bit typed, input t_reply tv);
        t_reply p;
        int g;
        s_axis_tdata = {5'b0, e.ok, e.rterm, e.conflict, e.idx, e.term, e.peer};
        s_axis_tuser = e.kind;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict(e, p);
        pending_replies.insert(pending_replies.size(), typed ? tv : p);
        @(negedge i_clk);
        if ($urandom_range(0, 49) == 0) calm = !calm;
        g = pick_gap();
        if (g > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending_replies.size() > 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic idx, input logic [10:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        if (idx == CFG_IDX_PEER_COUNT) cfg_peers = val[2:0];
        else cfg_batch = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // random event shaped by the current leader state
    task automatic gen(output t_event e);
        int r;
        logic [31:0] lo;
        e.kind = KIND_APPEND;
        e.peer = 2'($urandom_range(0, 3));
        e.term = cur_term;
        e.idx = $urandom;
        e.conflict = $urandom;
        e.rterm = $urandom;
        e.ok = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 30) begin
            if ($urandom_range(0, 99) == 0) e.term = $urandom;
        end else if (r < 35) begin
            e.kind = KIND_INIT;
            cur_term += $urandom_range(0, 1);
            e.term = cur_term;
        end else if (r < 65) begin
            e.kind = KIND_RESP;
            if ($urandom_range(0, 6) != 0) e.rterm = $urandom_range(0, cur_term);
            e.ok = $urandom_range(0, 3) != 0;
            lo = last_idx > 8 ? last_idx - 8 : 0;
            if ($urandom_range(0, 29) != 0) e.idx = $urandom_range(lo, last_idx);
            else if ($urandom_range(0, 1)) e.idx = 32'hFFFF_FFFF;
            if (!e.ok) begin
                if ($urandom_range(0, 1)) e.conflict = 0;
                else if ($urandom_range(0, 4) != 0)
                    e.conflict = $urandom_range(base_idx + 1, last_idx + 1);
            end
        end else if (r < 85) begin
            e.kind = KIND_BUILD;
        end else if (r < 97) begin
            e.kind = KIND_CUT;
            if (commit_idx > base_idx && $urandom_range(0, 4) != 0)
                e.idx = $urandom_range(base_idx + 1, commit_idx);
            else if ($urandom_range(0, 1)) e.idx = $urandom_range(0, last_idx + 2);
        end else begin
            e.kind = 3'($urandom_range(5, 7));
        end
    endtask

    task automatic add_row(input logic [2:0] k, input logic [1:0] p, input logic [31:0] t,
                           input logic [31:0] ix, input logic [31:0] c,
                           input logic [31:0] rt, input logic ok, input bit typed,
                           input t_reply rep);
        rows.insert(rows.size(), '{'{k, p, t, ix, c, rt, ok}, typed, rep});
    endtask

    initial begin
        t_reply none;
        t_event ev;
        int n;
        none = '{0, 0, 0, 0, 0, 0, 0, 0};
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed part, reset configuration
        add_row(KIND_BUILD, 0, 5, 0, 0, 0, 0, 1, '{STAT_DONE, 0, 0, 1, 0, 0, 0, 0});
        add_row(3'd7, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1,
                '{STAT_IGNORED, 0, 0, 0, 0, 0, 0, 0});
        add_row(KIND_APPEND, 0, 5, 0, 0, 0, 0, 1, '{STAT_DONE, 1, 0, 0, 0, 0, 0, 1});
        add_row(KIND_APPEND, 0, 5, 0, 0, 0, 0, 1, '{STAT_DONE, 2, 0, 0, 0, 0, 0, 2});
        add_row(KIND_INIT, 0, 5, 0, 0, 0, 0, 1, '{STAT_DONE, 0, 0, 0, 0, 0, 0, 2});
        add_row(KIND_RESP, 0, 5, 2, 0, 5, 1, 0, none);
        add_row(KIND_RESP, 1, 5, 2, 0, 5, 1, 0, none);
        // stale response: term carried above the leader's
        add_row(KIND_RESP, 2, 5, 2, 0, 6, 1, 1, '{STAT_IGNORED, 0, 0, 0, 0, 2, 0, 2});
        add_row(KIND_RESP, 3, 5, 0, 0, 5, 0, 0, none);
        add_row(KIND_RESP, 2, 5, 0, 32'hFFFF_FFFF, 0, 0, 0, none);
        add_row(KIND_BUILD, 2, 5, 0, 0, 0, 0, 0, none);
        add_row(KIND_BUILD, 3, 5, 0, 0, 0, 0, 0, none);
        // huge match index saturates next, median stays at the last index
        add_row(KIND_RESP, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1, 0, none);
        add_row(KIND_CUT, 0, 0, 1, 0, 0, 0, 0, none);
        add_row(KIND_CUT, 0, 0, 1, 0, 0, 0, 0, none);
        add_row(KIND_CUT, 0, 0, 5, 0, 0, 0, 0, none);
        add_row(KIND_BUILD, 1, 5, 0, 0, 0, 0, 0, none);
        add_row(KIND_BUILD, 3, 5, 0, 0, 0, 0, 0, none);
        add_row(KIND_APPEND, 0, 0, 0, 0, 0, 0, 0, none);
        add_row(KIND_RESP, 1, 0, 3, 0, 0, 1, 0, none);
        add_row(KIND_RESP, 3, 0, 3, 0, 0, 1, 0, none);
        add_row(KIND_CUT, 0, 0, 3, 0, 0, 0, 0, none);
        add_row(KIND_RESP, 3, 5, 0, 0, 5, 0, 0, none);
        add_row(KIND_BUILD, 3, 5, 0, 0, 0, 0, 0, none);
        foreach (rows[i]) send(rows[i].ev, rows[i].typed, rows[i].rep);
        cur_term = 6;

        drain();
        set_reg(CFG_IDX_MAX_BATCH, 11'd2047);
        repeat (150) begin
            gen(ev);
            send(ev, 0, none);
        end

        // no peers: nothing commits, so the ring fills up
        drain();
        set_reg(CFG_IDX_PEER_COUNT, 3'd0);
        set_reg(CFG_IDX_MAX_BATCH, 11'd0);
        send('{KIND_INIT, 0, cur_term, 0, 0, 0, 0}, 0, none);
        n = 0;
        while (n < 3) begin
            if (last_idx - base_idx >= DEPTH) n++;
            send('{KIND_APPEND, 0, cur_term, $urandom, $urandom, $urandom, 1'b0}, 0, none);
        end
        repeat (40) begin
            gen(ev);
            send(ev, 0, none);
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin set_reg(CFG_IDX_PEER_COUNT, 3'd1); set_reg(CFG_IDX_MAX_BATCH, 11'd1); end
                1: begin set_reg(CFG_IDX_PEER_COUNT, 3'd2); set_reg(CFG_IDX_MAX_BATCH, 11'd1024); end
                2: begin set_reg(CFG_IDX_PEER_COUNT, 3'd7); set_reg(CFG_IDX_MAX_BATCH, 11'd5); end
                default: begin
                    set_reg(CFG_IDX_PEER_COUNT, 3'd3);
                    set_reg(CFG_IDX_MAX_BATCH, 11'd300);
                end
            endcase
            send('{KIND_INIT, 0, cur_term, 0, 0, 0, 0}, 0, none);
            repeat (80) begin
                gen(ev);
                send(ev, 0, none);
            end
        end

        s_axis_tvalid = 1'b0;
        drain();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
